/* rtl/gcd_pkg.sv */
// ----------------------------------------------------------------------------
// gcd_pkg: shared types and constants for the great-circle distance unit
// Fixed-point formats, CORDIC arctangent table and angle-scaling tables.
// ----------------------------------------------------------------------------
package gcd_pkg;

  // CORDIC working word, vector component and product widths
  typedef logic signed [35:0] cw_t;
  typedef logic signed [33:0] vc_t;
  typedef logic signed [67:0] pr_t;

  typedef enum logic [1:0] {
    QUAD0 = 2'd0,
    QUAD1 = 2'd1,
    QUAD2 = 2'd2,
    QUAD3 = 2'd3
  } quad_t;

  localparam longint unsigned PI_Q30             = 64'd3373259426;
  localparam longint unsigned HALF_PI_Q30        = PI_Q30 / 2;
  localparam longint unsigned K_INV_Q30          = 64'd652032874;
  localparam longint unsigned QUARTER_TURN       = 64'd92160;
  localparam longint unsigned HALF_TURN          = 64'd184320;
  localparam longint unsigned THREE_QUARTER_TURN = 64'd276480;
  localparam longint unsigned FULL_TURN          = 64'd368640;

  // r / 45 for r below a quarter turn: (r * DIV45_MUL) >> DIV45_SHIFT
  localparam longint unsigned DIV45_MUL   = 64'd186414;
  localparam int              DIV45_SHIFT = 23;
  localparam int              ZC_N        = 45;

  localparam logic [29:0] ATAN_Q30 [32] = '{
    30'd843314856, 30'd497837829, 30'd263043836, 30'd133525158, 30'd67021686,
    30'd33543515,  30'd16775850,  30'd8388437,   30'd4194282,   30'd2097149,
    30'd1048575,   30'd524287,    30'd262143,    30'd131071,    30'd65535,
    30'd32767,     30'd16383,     30'd8191,      30'd4095,      30'd2047,
    30'd1023,      30'd511,       30'd255,       30'd127,       30'd63,
    30'd31,        30'd15,        30'd8,         30'd4,         30'd2,
    30'd1,         30'd0
  };

  typedef logic [19:0] zc_hi_arr_t [ZC_N];
  typedef logic [17:0] zc_lo_arr_t [ZC_N];

  // k * PI_Q30 split into quotient and remainder by a half turn
  function automatic zc_hi_arr_t zc_hi_build();
    zc_hi_arr_t      t;
    longint unsigned p;
    for (int k = 0; k < ZC_N; k++) begin
      p    = longint'(k) * PI_Q30;
      t[k] = 20'(p / HALF_TURN);
    end
    return t;
  endfunction

  function automatic zc_lo_arr_t zc_lo_build();
    zc_lo_arr_t      t;
    longint unsigned p;
    for (int k = 0; k < ZC_N; k++) begin
      p    = longint'(k) * PI_Q30;
      t[k] = 18'(p % HALF_TURN);
    end
    return t;
  endfunction

  localparam zc_hi_arr_t ZC_HI = zc_hi_build();
  localparam zc_lo_arr_t ZC_LO = zc_lo_build();

  // Q60 product back to Q30, round half up
  function automatic vc_t qround(pr_t p);
    pr_t t;
    t = p + (pr_t'(1) <<< 29);
    return vc_t'(t >>> 30);
  endfunction

endpackage

/* rtl/gcd_angle_prep.sv */
// ----------------------------------------------------------------------------
// gcd_angle_prep: angle reduction to quadrant and Q30 radians
// Four-stage pipeline: wrap and quadrant, divide by 45, scale, correct.
// ----------------------------------------------------------------------------
module gcd_angle_prep (
  input  logic               clk,
  input  logic               en,
  input  logic signed [19:0] ang_i,   // 1/1024 degree
  output logic        [30:0] z_o,     // Q30 radians, below a quarter turn
  output logic        [1:0]  q_o
);
  import gcd_pkg::*;

  logic signed [20:0] tw;
  logic [18:0] t;
  logic [18:0] rfull;
  quad_t       q1_nxt;
  logic [16:0] r1_r;
  quad_t       q1_r;

  logic [34:0] prod45;
  logic [10:0] qr2_r;
  logic [16:0] r2_r;
  quad_t       q2_r;

  logic [16:0] rr_full;
  logic [5:0]  rr3_r;
  logic [42:0] p3_r;
  quad_t       q3_r;

  logic [18:0] fsum;
  logic [1:0]  corr;
  logic [30:0] z4_nxt;
  logic [30:0] z4_r;
  quad_t       q4_r;

  // stage 1: wrap into one turn, split off the quadrant
  always_comb begin
    tw = 21'(ang_i) + ((ang_i < 0) ? 21'(FULL_TURN) : 21'd0);
    t  = tw[18:0];
    if (t >= 19'(THREE_QUARTER_TURN)) begin
      q1_nxt = QUAD3;
      rfull  = t - 19'(THREE_QUARTER_TURN);
    end else if (t >= 19'(HALF_TURN)) begin
      q1_nxt = QUAD2;
      rfull  = t - 19'(HALF_TURN);
    end else if (t >= 19'(QUARTER_TURN)) begin
      q1_nxt = QUAD1;
      rfull  = t - 19'(QUARTER_TURN);
    end else begin
      q1_nxt = QUAD0;
      rfull  = t;
    end
  end

  assign prod45  = 35'(r1_r) * 35'(DIV45_MUL);
  assign rr_full = r2_r - 17'(qr2_r) * 17'd45;

  // r * PI = half_turn * (A + hi) + 45 * B + lo; fold the small part back in
  always_comb begin
    fsum = 19'(p3_r[11:0]) * 19'd45 + 19'(ZC_LO[rr3_r]) + 19'(QUARTER_TURN);
    if (fsum >= 19'(FULL_TURN)) begin
      corr = 2'd2;
    end else if (fsum >= 19'(HALF_TURN)) begin
      corr = 2'd1;
    end else begin
      corr = 2'd0;
    end
    z4_nxt = p3_r[42:12] + 31'(ZC_HI[rr3_r]) + 31'(corr);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r1_r  <= rfull[16:0];
      q1_r  <= q1_nxt;
      qr2_r <= prod45[DIV45_SHIFT+10:DIV45_SHIFT];
      r2_r  <= r1_r;
      q2_r  <= q1_r;
      rr3_r <= rr_full[5:0];
      p3_r  <= 43'(qr2_r) * 43'(PI_Q30);
      q3_r  <= q2_r;
      z4_r  <= z4_nxt;
      q4_r  <= q3_r;
    end
  end

  assign z_o = z4_r;
  assign q_o = q4_r;

endmodule

/* rtl/gcd_cordic_cell.sv */
// ----------------------------------------------------------------------------
// gcd_cordic_cell: one registered CORDIC micro-rotation
// Rotation mode steers on z, vectoring mode on y; side data rides along.
// ----------------------------------------------------------------------------
module gcd_cordic_cell #(
  parameter int STEP   = 0,
  parameter bit VECTOR = 1'b0,
  parameter int SIDE_W = 2
) (
  input  logic                clk,
  input  logic                en,
  input  gcd_pkg::cw_t        x_i,
  input  gcd_pkg::cw_t        y_i,
  input  gcd_pkg::cw_t        z_i,
  input  logic [SIDE_W-1:0]   side_i,
  output gcd_pkg::cw_t        x_o,
  output gcd_pkg::cw_t        y_o,
  output gcd_pkg::cw_t        z_o,
  output logic [SIDE_W-1:0]   side_o
);
  import gcd_pkg::*;

  cw_t dx, dy, da;
  logic pos;
  cw_t x_nxt, y_nxt, z_nxt;
  cw_t x_r, y_r, z_r;
  logic [SIDE_W-1:0] side_r;

  always_comb begin
    dx  = y_i >>> STEP;
    dy  = x_i >>> STEP;
    da  = cw_t'(ATAN_Q30[STEP]);
    pos = VECTOR ? (y_i > 0) : (z_i >= 0);
    if (pos ^ VECTOR) begin
      x_nxt = x_i - dx;
      y_nxt = y_i + dy;
      z_nxt = z_i - da;
    end else begin
      x_nxt = x_i + dx;
      y_nxt = y_i - dy;
      z_nxt = z_i + da;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r    <= x_nxt;
      y_r    <= y_nxt;
      z_r    <= z_nxt;
      side_r <= side_i;
    end
  end

  assign x_o    = x_r;
  assign y_o    = y_r;
  assign z_o    = z_r;
  assign side_o = side_r;

endmodule

/* rtl/gcd_sqrt_cell.sv */
// ----------------------------------------------------------------------------
// gcd_sqrt_cell: one registered step of the integer square root
// Tries one result bit per cell against the remaining radicand.
// ----------------------------------------------------------------------------
module gcd_sqrt_cell #(
  parameter int STEP   = 0,
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              en,
  input  logic [63:0]       v_i,
  input  logic [63:0]       res_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic [63:0]       v_o,
  output logic [63:0]       res_o,
  output logic [SIDE_W-1:0] side_o
);

  localparam logic [63:0] BIT = 64'd1 << (62 - 2 * STEP);

  logic [63:0] trial;
  logic [63:0] v_nxt, res_nxt;
  logic [63:0] v_r, res_r;
  logic [SIDE_W-1:0] side_r;

  always_comb begin
    trial = res_i + BIT;
    if (v_i >= trial) begin
      v_nxt   = v_i - trial;
      res_nxt = (res_i >> 1) + BIT;
    end else begin
      v_nxt   = v_i;
      res_nxt = res_i >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      v_r    <= v_nxt;
      res_r  <= res_nxt;
      side_r <= side_i;
    end
  end

  assign v_o    = v_r;
  assign res_o  = res_r;
  assign side_o = side_r;

endmodule

/* rtl/great_circle_distance_unit.sv */
// Pipeline depth: set by the two CORDIC chains (steps capped at 32), the
//   32-cell square-root chain and the product stages.
// Throughput: one item per cycle; the whole pipeline holds while a result
//   waits at the output.
// Reset: synchronous, active low; clears the stage valid bits only.
// ----------------------------------------------------------------------------
// great_circle_distance_unit: pipelined great-circle arc length
// Points become unit vectors by rotation CORDIC, the central angle comes
// from atan2 of cross-product magnitude and dot product, scaled by radius.
// ----------------------------------------------------------------------------
module great_circle_distance_unit #(
  parameter int CORDIC_STEPS = 24
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [95:0] in_tdata,   // radius, lat_one, lon_one, lat_two, lon_two
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata   // distance
);
  import gcd_pkg::*;

  localparam int N       = (CORDIC_STEPS > 32) ? 32 : CORDIC_STEPS;
  localparam int RAD_DLY = 43 + N;
  localparam int LAT     = 47 + 2 * N;
  localparam int SQ_V    = 42 + N;
  localparam int ANG_V   = LAT - 3;

  logic en;
  logic [LAT-1:0] vld_r;

  logic signed [19:0] ang [4];
  logic [30:0] pz [4];
  logic [1:0]  pq [4];

  cw_t        rx [4][N+1];
  cw_t        ry [4][N+1];
  cw_t        rz [4][N+1];
  logic [1:0] rq [4][N+1];

  vc_t c_r [4];
  vc_t s_r [4];
  pr_t up0_r [2];
  pr_t up1_r [2];
  vc_t uz_r  [2];
  vc_t v_r   [2][3];
  pr_t p_r   [9];
  vc_t cx_r, cy_r, cz_r, dot_r;
  logic [63:0] sqp_r [3];
  vc_t dot_q1_r, dot_q2_r;
  logic [63:0] sq_r;

  logic [63:0] sv   [33];
  logic [63:0] sres [33];
  logic [33:0] sdot [33];

  logic [19:0] rad_r [RAD_DLY];

  cw_t         vx [N+1];
  cw_t         vy [N+1];
  cw_t         vz [N+1];
  logic [19:0] vrad [N+1];
  vc_t         dsq;

  logic [31:0] ang_r;
  logic [19:0] rad_c_r;
  logic [51:0] prod_r;
  logic [52:0] rnd;
  logic [29:0] dist_r;

  // advance everything unless a finished result is held
  assign en         = !out_tvalid || out_tready;
  assign in_tready  = en;
  assign out_tvalid = vld_r[LAT-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LAT-2:0], in_tvalid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rad_r[0] <= in_tdata[19:0];
      for (int k = 1; k < RAD_DLY; k++) begin
        rad_r[k] <= rad_r[k-1];
      end
    end
  end

  // polar angles get a quarter-turn offset
  assign ang[0] = 20'(signed'(in_tdata[37:20])) + 20'(QUARTER_TURN);
  assign ang[1] = 20'(signed'(in_tdata[56:38]));
  assign ang[2] = 20'(signed'(in_tdata[74:57])) + 20'(QUARTER_TURN);
  assign ang[3] = 20'(signed'(in_tdata[93:75]));

  for (genvar a = 0; a < 4; a++) begin : g_rot
    gcd_angle_prep u_prep (
      .clk   (clk),
      .en    (en),
      .ang_i (ang[a]),
      .z_o   (pz[a]),
      .q_o   (pq[a])
    );

    assign rx[a][0] = cw_t'(K_INV_Q30);
    assign ry[a][0] = '0;
    assign rz[a][0] = cw_t'(pz[a]);
    assign rq[a][0] = pq[a];

    for (genvar i = 0; i < N; i++) begin : g_cell
      gcd_cordic_cell #(
        .STEP   (i),
        .VECTOR (1'b0),
        .SIDE_W (2)
      ) u_cell (
        .clk    (clk),
        .en     (en),
        .x_i    (rx[a][i]),
        .y_i    (ry[a][i]),
        .z_i    (rz[a][i]),
        .side_i (rq[a][i]),
        .x_o    (rx[a][i+1]),
        .y_o    (ry[a][i+1]),
        .z_o    (rz[a][i+1]),
        .side_o (rq[a][i+1])
      );
    end
  end

  // quadrant fix-up, unit vectors, cross and dot products, squares
  always_ff @(posedge clk) begin
    if (en) begin
      for (int a = 0; a < 4; a++) begin
        case (quad_t'(rq[a][N]))
          QUAD0: begin
            c_r[a] <= vc_t'(rx[a][N]);
            s_r[a] <= vc_t'(ry[a][N]);
          end
          QUAD1: begin
            c_r[a] <= vc_t'(-ry[a][N]);
            s_r[a] <= vc_t'(rx[a][N]);
          end
          QUAD2: begin
            c_r[a] <= vc_t'(-rx[a][N]);
            s_r[a] <= vc_t'(-ry[a][N]);
          end
          default: begin
            c_r[a] <= vc_t'(ry[a][N]);
            s_r[a] <= vc_t'(-rx[a][N]);
          end
        endcase
      end
      for (int k = 0; k < 2; k++) begin
        up0_r[k]  <= pr_t'(c_r[2*k+1]) * pr_t'(s_r[2*k]);
        up1_r[k]  <= pr_t'(s_r[2*k+1]) * pr_t'(s_r[2*k]);
        uz_r[k]   <= c_r[2*k];
        v_r[k][0] <= qround(up0_r[k]);
        v_r[k][1] <= qround(up1_r[k]);
        v_r[k][2] <= uz_r[k];
      end
      p_r[0] <= pr_t'(v_r[0][1]) * pr_t'(v_r[1][2]);
      p_r[1] <= pr_t'(v_r[0][2]) * pr_t'(v_r[1][1]);
      p_r[2] <= pr_t'(v_r[0][2]) * pr_t'(v_r[1][0]);
      p_r[3] <= pr_t'(v_r[0][0]) * pr_t'(v_r[1][2]);
      p_r[4] <= pr_t'(v_r[0][0]) * pr_t'(v_r[1][1]);
      p_r[5] <= pr_t'(v_r[0][1]) * pr_t'(v_r[1][0]);
      p_r[6] <= pr_t'(v_r[0][0]) * pr_t'(v_r[1][0]);
      p_r[7] <= pr_t'(v_r[0][1]) * pr_t'(v_r[1][1]);
      p_r[8] <= pr_t'(v_r[0][2]) * pr_t'(v_r[1][2]);
      cx_r   <= qround(p_r[0] - p_r[1]);
      cy_r   <= qround(p_r[2] - p_r[3]);
      cz_r   <= qround(p_r[4] - p_r[5]);
      dot_r  <= qround(p_r[6] + p_r[7] + p_r[8]);
      sqp_r[0] <= 64'(pr_t'(cx_r) * pr_t'(cx_r));
      sqp_r[1] <= 64'(pr_t'(cy_r) * pr_t'(cy_r));
      sqp_r[2] <= 64'(pr_t'(cz_r) * pr_t'(cz_r));
      dot_q1_r <= dot_r;
      sq_r     <= sqp_r[0] + sqp_r[1] + sqp_r[2];
      dot_q2_r <= dot_q1_r;
    end
  end

  assign sv[0]   = sq_r;
  assign sres[0] = '0;
  assign sdot[0] = dot_q2_r;

  for (genvar i = 0; i < 32; i++) begin : g_sqrt
    gcd_sqrt_cell #(
      .STEP   (i),
      .SIDE_W (34)
    ) u_cell (
      .clk    (clk),
      .en     (en),
      .v_i    (sv[i]),
      .res_i  (sres[i]),
      .side_i (sdot[i]),
      .v_o    (sv[i+1]),
      .res_o  (sres[i+1]),
      .side_o (sdot[i+1])
    );
  end

  // atan2 setup: turn a negative dot product by a quarter turn
  assign dsq = signed'(sdot[32]);

  always_ff @(posedge clk) begin
    if (en) begin
      vrad[0] <= rad_r[RAD_DLY-1];
      if (dsq < 0) begin
        vx[0] <= cw_t'(sres[32][31:0]);
        vy[0] <= -cw_t'(dsq);
        vz[0] <= cw_t'(HALF_PI_Q30);
      end else begin
        vx[0] <= cw_t'(dsq);
        vy[0] <= cw_t'(sres[32][31:0]);
        vz[0] <= '0;
      end
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_vec
    gcd_cordic_cell #(
      .STEP   (i),
      .VECTOR (1'b1),
      .SIDE_W (20)
    ) u_cell (
      .clk    (clk),
      .en     (en),
      .x_i    (vx[i]),
      .y_i    (vy[i]),
      .z_i    (vz[i]),
      .side_i (vrad[i]),
      .x_o    (vx[i+1]),
      .y_o    (vy[i+1]),
      .z_o    (vz[i+1]),
      .side_o (vrad[i+1])
    );
  end

  assign rnd = 53'(prod_r) + (53'd1 << 21);

  // clamp to [0, pi], scale by radius, round to 1/256
  always_ff @(posedge clk) begin
    if (en) begin
      if (vz[N] < 0) begin
        ang_r <= '0;
      end else if (vz[N] > cw_t'(PI_Q30)) begin
        ang_r <= 32'(PI_Q30);
      end else begin
        ang_r <= vz[N][31:0];
      end
      rad_c_r <= vrad[N];
      prod_r  <= 52'(rad_c_r) * 52'(ang_r);
      dist_r  <= rnd[51:22];
    end
  end

  assign out_tdata = {2'b00, dist_r};

  a_accept_enters : assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> vld_r[0])
    else $error("accepted item not captured in first stage");

  a_sqrt_width : assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[SQ_V] |-> sres[32][63:32] == '0)
    else $error("square root result exceeds 32 bits");

  a_angle_clamp : assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[ANG_V] |-> ang_r <= 32'(PI_Q30))
    else $error("central angle above pi");

endmodule
